[rtl/abe_pkg.sv]
// Shared types and constants for the addressable LED bit encoder.
`default_nettype none

package abe_pkg;

  // Function codes carried in the input word.
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_START = 2'd1,
    FUNC_SLOT  = 2'd2
  } func_t;

  // Configuration register indexes.
  localparam logic [7:0] REG_BIT_ONE  = 8'd0;
  localparam logic [7:0] REG_BIT_ZERO = 8'd1;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned DUTY_W     = 16;
  localparam int unsigned BIT_IDX_W  = 5;

  // Bits per LED and the position of the first bit sent for each LED.
  localparam int unsigned BITS_PER_LED = 24;
  localparam logic [BIT_IDX_W-1:0] BIT_MSB = 5'd23;

  localparam logic [DUTY_W-1:0] BIT_ONE_RESET  = 16'd60;
  localparam logic [DUTY_W-1:0] BIT_ZERO_RESET = 16'd30;

  // One LED entry, packed green, red, blue from the top down.
  typedef struct packed {
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
  } colour_t;

  // One result word.
  typedef struct packed {
    logic [DUTY_W-1:0] slot_duty;
    logic              frame_end;
  } result_t;

endpackage

`default_nettype wire

[rtl/abe_in_if.sv]
// Input channel interface: command words for the LED bit encoder.
`default_nettype none

interface abe_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] led_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output func, output led_index, output red,
                  output green, output blue, input ready);
  modport sink   (input valid, input func, input led_index, input red,
                  input green, input blue, output ready);
endinterface

`default_nettype wire

[rtl/abe_out_if.sv]
// Result channel interface: one PWM compare value per bit slot.
`default_nettype none

interface abe_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] slot_duty;
  logic        frame_end;

  modport source (output valid, output slot_duty, output frame_end, input ready);
  modport sink   (input valid, input slot_duty, input frame_end, output ready);
endinterface

`default_nettype wire

[rtl/abe_cfg_if.sv]
// Configuration write channel interface: register index and write data.
`default_nettype none

interface abe_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/abe_colour_store.sv]
// Colour store: one entry per LED, per-entry valid bits, registered read port.
`default_nettype none

module abe_colour_store #(
  parameter int unsigned LED_COUNT = 8,
  parameter int unsigned IDX_W     = 3,
  parameter int unsigned CNT_W     = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [IDX_W-1:0]     wr_addr,
  input  wire abe_pkg::colour_t     wr_data,
  input  wire logic [CNT_W-1:0]     rd_addr,
  output      abe_pkg::colour_t     rd_data_r
);
  import abe_pkg::*;

  colour_t              mem [LED_COUNT];
  logic [LED_COUNT-1:0] valid_r;
  logic                 rd_in_range;

  // Addresses at or past the end of the chain read as zero.
  assign rd_in_range = (rd_addr < CNT_W'(LED_COUNT));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_in_range && valid_r[rd_addr[IDX_W-1:0]]) begin
      rd_data_r <= mem[rd_addr[IDX_W-1:0]];
    end else begin
      rd_data_r <= '0;
    end
  end

endmodule

`default_nettype wire

[rtl/addressable_led_bit_encoder.sv]
// Top level of the addressable LED bit encoder: colour store and slot sequencer.
//
// The block keeps one 24-bit colour per LED and turns the store into a frame
// of PWM compare values. Each word on the input channel carries a function:
// a colour write (ignored while a frame is sending or when the LED index is
// past the chain), a frame start (taken only when the store changed since the
// last frame and no frame is sending), or a slot request. While a frame is
// sending, each slot request returns one word on the result channel: the one
// or zero compare value for the next bit, green, red, blue, MSB first, LED by
// LED, and after the last data bit one word with duty zero and frame_end set,
// which closes the frame. Other words produce no result.
// Throughput is one input word per cycle while input ready is high. Results are
// registered in the output register, or in the skid register while it is held.
// The current LED's colour is read ahead from the store's registered read port.
// A two-entry output stage (output register plus skid register) lets the
// block keep taking words while a result waits; input ready drops only when
// both entries are full, so a stalled receiver holds everything in place.
// The configuration channel is always ready and takes the one and zero duty
// values; writes to other indexes are dropped.
// Synchronous reset clears the colour store valid bits (all LEDs read as
// black), the changed and busy flags, and restores duties of 60 and 30.
`default_nettype none

module addressable_led_bit_encoder #(
  parameter int unsigned LED_COUNT = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  abe_in_if.sink    in_ch,
  abe_out_if.source out_ch,
  abe_cfg_if.sink   cfg_ch
);
  import abe_pkg::*;

  // Store address width and the width of a counter that can hold LED_COUNT.
  localparam int unsigned IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(LED_COUNT + 1);

  // Duty registers.
  logic [DUTY_W-1:0] bit_one_r;
  logic [DUTY_W-1:0] bit_zero_r;

  // Frame control state. led_r is the LED of the next slot and bit_r the
  // bit within it; led_r equal to LED_COUNT means only the end slot is left.
  logic                 busy_r, busy_nxt;
  logic                 changed_r, changed_nxt;
  logic [CNT_W-1:0]     led_r, led_nxt;
  logic [BIT_IDX_W-1:0] bit_r, bit_nxt;

  // Output stage.
  logic    out_valid_r, skid_valid_r;
  result_t out_data_r, skid_data_r;
  logic    pop;

  logic    accept;
  logic    wr_en;
  logic    in_range;
  logic    res_valid;
  result_t res;
  colour_t wr_data;
  colour_t cur_colour;

  assign in_ch.ready  = !skid_valid_r;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;

  assign in_range      = ({1'b0, in_ch.led_index} < 9'(LED_COUNT));
  assign wr_data.green = in_ch.green;
  assign wr_data.red   = in_ch.red;
  assign wr_data.blue  = in_ch.blue;

  // Next state of the frame sequencer and the result of this word.
  always_comb begin
    busy_nxt      = busy_r;
    changed_nxt   = changed_r;
    led_nxt       = led_r;
    bit_nxt       = bit_r;
    wr_en         = 1'b0;
    res_valid     = 1'b0;
    res.slot_duty = '0;
    res.frame_end = 1'b0;
    if (accept) begin
      unique case (in_ch.func)
        FUNC_WRITE: begin
          if (!busy_r && in_range) begin
            wr_en       = 1'b1;
            changed_nxt = 1'b1;
          end
        end
        FUNC_START: begin
          if (changed_r && !busy_r) begin
            busy_nxt    = 1'b1;
            changed_nxt = 1'b0;
            led_nxt     = '0;
            bit_nxt     = BIT_MSB;
          end
        end
        FUNC_SLOT: begin
          if (busy_r) begin
            res_valid = 1'b1;
            if (led_r == CNT_W'(LED_COUNT)) begin
              // End-of-frame reset slot.
              res.frame_end = 1'b1;
              busy_nxt      = 1'b0;
              led_nxt       = '0;
              bit_nxt       = BIT_MSB;
            end else begin
              res.slot_duty = cur_colour[bit_r] ? bit_one_r : bit_zero_r;
              if (bit_r == '0) begin
                bit_nxt = BIT_MSB;
                led_nxt = led_r + CNT_W'(1);
              end else begin
                bit_nxt = bit_r - BIT_IDX_W'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The store is read at the LED the next slot will use, so its registered
  // output always holds the current LED's colour. Writes only happen while
  // idle, when the read address sits at LED zero.
  abe_colour_store #(
    .LED_COUNT (LED_COUNT),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (in_ch.led_index[IDX_W-1:0]),
    .wr_data   (wr_data),
    .rd_addr   (led_nxt),
    .rd_data_r (cur_colour)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      changed_r <= 1'b0;
      led_r     <= '0;
      bit_r     <= BIT_MSB;
    end else begin
      busy_r    <= busy_nxt;
      changed_r <= changed_nxt;
      led_r     <= led_nxt;
      bit_r     <= bit_nxt;
    end
  end

  // Duty registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_one_r  <= BIT_ONE_RESET;
      bit_zero_r <= BIT_ZERO_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_BIT_ONE) begin
        bit_one_r <= cfg_ch.data;
      end else if (cfg_ch.index == REG_BIT_ZERO) begin
        bit_zero_r <= cfg_ch.data;
      end
    end
  end

  // Output register with a skid entry behind it. New results only arrive
  // when the skid entry is empty, because input ready follows it.
  assign pop = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= res_valid;
      end else begin
        out_valid_r  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_data_r  <= skid_data_r;
        skid_data_r <= res;
      end else begin
        out_data_r  <= res;
      end
    end else if (res_valid) begin
      skid_data_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.slot_duty = out_data_r.slot_duty;
  assign out_ch.frame_end = out_data_r.frame_end;

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the addressable LED bit encoder.
`timescale 1ns / 1ps

module tb;
  import abe_pkg::*;

  // Chain length used for the block under test and for the local predictor.
  localparam int unsigned LED_COUNT  = 8;
  localparam int unsigned DATA_SLOTS = LED_COUNT * BITS_PER_LED;

  // The function code that the block must ignore.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // A configuration index that maps to no register; the block drops it.
  localparam logic [7:0] REG_SPARE = 8'hFF;

  // Random command words per phase that actually change state or yield a slot.
  localparam int unsigned WORDS_PER_PHASE = 410;

  // Quiet cycles allowed for words still in flight before a register write.
  localparam int unsigned DRAIN_CYCLES = 16;

  // Length of the one long receiver stall in the last phase.
  localparam int unsigned HOLD_CYCLES = 300;

  // Run limit. A correct run needs far fewer cycles than this.
  localparam int unsigned LIMIT_CYCLES = 400000;

  // One row of the directed part. When typed is set, the expected result
  // (or its absence) is taken from the row itself; otherwise the predictor
  // supplies it.
  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  idx;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        typed;
    logic        has_res;
    logic [15:0] duty;
    logic        frame_end;
  } cmd_row_t;

  localparam int unsigned DIRECTED_COUNT = 23;

  localparam cmd_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // Slot request with no frame running gives nothing.
    '{FUNC_SLOT,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 16'd0, 1'b0},
    // Start with an unchanged store is ignored.
    '{FUNC_START,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 16'd0, 1'b0},
    // The unused function code with every field bit set.
    '{FUNC_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 16'd0, 1'b0},
    // Writes just past the chain and at the top index are dropped.
    '{FUNC_WRITE,  8'd8,  8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 16'd0, 1'b0},
    '{FUNC_WRITE,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 16'd0, 1'b0},
    // So the store is still unchanged and the start is ignored again.
    '{FUNC_START,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 16'd0, 1'b0},
    '{FUNC_SLOT,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 16'd0, 1'b0},
    // First and last LED get extreme colours, then a frame starts.
    '{FUNC_WRITE,  8'h00, 8'h00, 8'hFF, 8'hA5, 1'b1, 1'b0, 16'd0, 1'b0},
    '{FUNC_WRITE,  8'h07, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0, 16'd0, 1'b0},
    '{FUNC_START,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 16'd0, 1'b0},
    // Green of LED 0 is all ones, so the first slots carry the reset one duty.
    '{FUNC_SLOT,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, BIT_ONE_RESET, 1'b0},
    '{FUNC_SLOT,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, BIT_ONE_RESET, 1'b0},
    // Write and start while the frame is sending are both ignored.
    '{FUNC_WRITE,  8'h01, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 16'd0, 1'b0},
    '{FUNC_START,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 16'd0, 1'b0},
    '{FUNC_SLOT,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, BIT_ONE_RESET, 1'b0},
    '{FUNC_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 16'd0, 1'b0},
    // The rest of the directed part is left to the predictor.
    '{FUNC_SLOT,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 16'd0, 1'b0},
    '{FUNC_SLOT,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 16'd0, 1'b0},
    '{FUNC_SLOT,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 16'd0, 1'b0},
    '{FUNC_SLOT,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 16'd0, 1'b0},
    '{FUNC_SLOT,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 16'd0, 1'b0},
    '{FUNC_WRITE,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 16'd0, 1'b0},
    '{FUNC_SLOT,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 16'd0, 1'b0}
  };

  logic clk;
  logic rst_n;

  abe_in_if  in_ch ();
  abe_out_if out_ch ();
  abe_cfg_if cfg_ch ();

  addressable_led_bit_encoder #(
    .LED_COUNT(LED_COUNT)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: a private copy of the colour store, the flags, the slot
  // position and the two duty registers.
  colour_t     led_store [LED_COUNT];
  bit          store_changed;
  bit          frame_busy;
  int unsigned next_slot;
  logic [15:0] duty_one;
  logic [15:0] duty_zero;

  // Slot words predicted but not yet seen on the result channel, oldest first.
  result_t pending_slots [$];

  // Idle rates of both sides, in percent, changed between phases.
  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 50;

  // A nonzero value asks the receiver process for one long stall.
  int unsigned hold_req = 0;
  int unsigned held_cycles = 0;

  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned words_sent = 0;
  int unsigned slots_checked = 0;
  int unsigned frames_done = 0;
  int unsigned reg_writes = 0;

  // Free-running clock, 10 ns period.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit. Any hang in a handshake ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Run limit of %0d cycles reached with %0d slot words outstanding.",
               LIMIT_CYCLES, pending_slots.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  // Predict the effect of one accepted command word. effective tells whether
  // the word did anything at all: a stored colour, a started frame or a slot.
  function automatic void encode_step(input logic [1:0] func, input logic [7:0] idx,
                                      input logic [7:0] red, input logic [7:0] green,
                                      input logic [7:0] blue, output bit has_res,
                                      output result_t res, output bit effective);
    int unsigned led;
    int unsigned bit_pos;
    has_res   = 1'b0;
    res       = '0;
    effective = 1'b0;
    case (func)
      FUNC_WRITE: begin
        // Colour writes land only inside the chain and only between frames.
        if (idx < LED_COUNT && !frame_busy) begin
          led_store[idx] = {green, red, blue};
          store_changed  = 1'b1;
          effective      = 1'b1;
        end
      end
      FUNC_START: begin
        if (store_changed && !frame_busy) begin
          frame_busy    = 1'b1;
          store_changed = 1'b0;
          next_slot     = 0;
          effective     = 1'b1;
        end
      end
      FUNC_SLOT: begin
        if (frame_busy) begin
          has_res   = 1'b1;
          effective = 1'b1;
          if (next_slot >= DATA_SLOTS) begin
            // The closing slot: duty zero, frame end set, frame over.
            res.slot_duty = '0;
            res.frame_end = 1'b1;
            frame_busy    = 1'b0;
            next_slot     = 0;
            frames_done++;
          end else begin
            // LED by LED, green, red, blue, most significant bit first.
            led           = next_slot / BITS_PER_LED;
            bit_pos       = BIT_MSB - (next_slot % BITS_PER_LED);
            res.slot_duty = led_store[led][bit_pos] ? duty_one : duty_zero;
            res.frame_end = 1'b0;
            next_slot++;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Colour values lean toward the extremes now and then.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one command word, starting and ending at a falling edge. The
  // sender may idle first. The word is accepted at the first rising edge
  // with ready high, and the predictor runs at that edge. A typed row
  // overrides what the predictor would expect.
  task automatic issue_command(input logic [1:0] func, input logic [7:0] idx,
                               input logic [7:0] red, input logic [7:0] green,
                               input logic [7:0] blue, input bit typed,
                               input bit typed_has, input result_t typed_res,
                               output bit effective);
    bit      has_res;
    result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= func;
    in_ch.led_index <= idx;
    in_ch.red       <= red;
    in_ch.green     <= green;
    in_ch.blue      <= blue;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    encode_step(func, idx, red, green, blue, has_res, res, effective);
    if (typed) begin
      has_res = typed_has;
      res     = typed_res;
    end
    if (has_res) pending_slots.push_back(res);
    words_sent++;
    @(negedge clk);
  endtask

  // Write one configuration register, starting and ending at a falling edge.
  task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    if (idx == REG_BIT_ONE) begin
      duty_one = value;
    end else if (idx == REG_BIT_ZERO) begin
      duty_zero = value;
    end
    reg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stop offering words, wait until every predicted slot word has come back,
  // then allow a few cycles for words that cause no result. Ends at a
  // falling edge.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver: drives ready at each falling edge. A pending hold request turns
  // into one long stall, counted here, during which the sender keeps offering
  // words until the output stage fills and input ready drops.
  initial begin : receiver
    int unsigned hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left   = hold_req;
        held_cycles = hold_req;
        hold_req    = 0;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Checker: every accepted slot word is compared with the oldest prediction.
  always @(posedge clk) begin : slot_checker
    result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      slots_checked++;
      if (pending_slots.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("[%0t] unexpected slot word: duty %0d frame_end %0b", $realtime,
                   out_ch.slot_duty, out_ch.frame_end);
        end
      end else begin
        want = pending_slots.pop_front();
        if (out_ch.slot_duty !== want.slot_duty || out_ch.frame_end !== want.frame_end) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("[%0t] slot word mismatch: expected duty %0d frame_end %0b, got duty %0d frame_end %0b",
                     $realtime, want.slot_duty, want.frame_end, out_ch.slot_duty,
                     out_ch.frame_end);
          end
        end
      end
    end
  end

  // Stimulus: reset, the directed table, then three random phases with
  // different idle patterns and duty settings.
  initial begin : stimulus
    cmd_row_t    row;
    logic [1:0]  func;
    logic [7:0]  idx;
    int unsigned pick;
    int unsigned done_words;
    bit          effective;
    bit          hold_done;

    // Every input is known from time zero.
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.func      = FUNC_WRITE;
    in_ch.led_index = '0;
    in_ch.red       = '0;
    in_ch.green     = '0;
    in_ch.blue      = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_BIT_ONE;
    cfg_ch.data     = '0;
    hold_done       = 1'b0;

    // Predictor starts from the reset state of the block.
    foreach (led_store[i]) led_store[i] = '0;
    store_changed = 1'b0;
    frame_busy    = 1'b0;
    next_slot     = 0;
    duty_one      = BIT_ONE_RESET;
    duty_zero     = BIT_ZERO_RESET;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part with the reset duties still in place.
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      row = DIRECTED_ROWS[i];
      issue_command(row.func, row.idx, row.red, row.green, row.blue, row.typed,
                    row.has_res, {row.duty, row.frame_end}, effective);
    end

    for (int phase = 0; phase < 3; phase++) begin
      drain_block();
      // Duty settings: the two extremes each way, then arbitrary values.
      // A frame may still be running here, so later slots pick up the new
      // duties in the middle of a frame.
      case (phase)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 50;
          write_reg(REG_BIT_ONE, 16'hFFFF);
          write_reg(REG_BIT_ZERO, 16'h0000);
        end
        1: begin
          send_idle_pct = 50;
          recv_idle_pct = 29;
          write_reg(REG_BIT_ONE, 16'h0000);
          write_reg(REG_BIT_ZERO, 16'hFFFF);
          write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_reg(REG_BIT_ONE, 16'($urandom_range(1, 65534)));
          write_reg(REG_BIT_ZERO, 16'($urandom_range(1, 65534)));
        end
      endcase

      done_words = 0;
      while (done_words < WORDS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        idx  = 8'($urandom_range(0, 255));
        // While a frame runs, the traffic is mostly slot requests with some
        // writes and starts that the block must ignore. Between frames it
        // is mostly colour writes and starts, with stray slot requests.
        if (frame_busy) begin
          if (pick < 90) func = FUNC_SLOT;
          else if (pick < 94) func = FUNC_WRITE;
          else if (pick < 97) func = FUNC_START;
          else func = FUNC_UNUSED;
        end else begin
          if (pick < 60) func = FUNC_WRITE;
          else if (pick < 85) func = FUNC_START;
          else if (pick < 95) func = FUNC_SLOT;
          else func = FUNC_UNUSED;
        end
        // Most writes hit the chain; the rest may fall past its end.
        if (func == FUNC_WRITE && $urandom_range(0, 9) != 0) begin
          idx = 8'($urandom_range(0, LED_COUNT - 1));
        end
        issue_command(func, idx, rand_byte(), rand_byte(), rand_byte(), 1'b0, 1'b0,
                      '0, effective);
        if (effective) done_words++;
        // In the last phase, stall the receiver once while a frame is running.
        if (phase == 2 && frame_busy && !hold_done) begin
          hold_req  = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
    end

    // Let everything come back, then watch a little longer for stray words.
    in_ch.valid <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d command words and checked %0d slot words over %0d completed frames.",
             words_sent, slots_checked, frames_done);
    $display("Made %0d register writes over four duty settings; receiver stalled %0d cycles once.",
             reg_writes, held_cycles);
    if (fail_count == 0 && pending_slots.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
